// File: src/lpcd_pkg.sv
// Package: shared types and constants of the page cache directory.
`timescale 1ns / 1ps
package lpcd_pkg;

    localparam int TagW   = 39;
    localparam int StampW = 64;
    localparam int LbaW   = 48;

    typedef enum logic [1:0] {
        ST_INVALID = 2'd0,
        ST_CLEAN   = 2'd1,
        ST_DIRTY   = 2'd2,
        ST_WRITING = 2'd3
    } entry_state_t;

    typedef enum logic [2:0] {
        OP_FETCH    = 3'd0,
        OP_MARK     = 3'd1,
        OP_FLUSH    = 3'd2,
        OP_WB_DONE  = 3'd3,
        OP_FILL_ERR = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        RS_HIT       = 3'd0,
        RS_FILLED    = 3'd1,
        RS_NO_VICTIM = 3'd2,
        RS_DONE      = 3'd3,
        RS_NOT_CACHE = 3'd4,
        RS_NO_DIRTY  = 3'd5,
        RS_IGNORED   = 3'd6
    } status_t;

    localparam logic [0:0] CFG_PAGE_SHIFT   = 1'd0;
    localparam logic [0:0] CFG_SECTOR_SHIFT = 1'd1;

    // Result of one directory operation, status in the lowest bits.
    typedef struct packed {
        logic [7:0]      sector_count;
        logic [LbaW-1:0] writeback_lba;
        logic            writeback_needed;
        logic [LbaW-1:0] read_lba;
        logic [7:0]      entry_index;
        logic [2:0]      status;
    } result_t;

endpackage

// File: src/lpcd_engine.sv
// Engine: walks the directory memories to serve one operation at a time.
`timescale 1ns / 1ps
module lpcd_engine #(
    parameter int CACHE_ENTRIES = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [2:0]            opcode,
    input  logic [47:0]           region_offset,
    input  logic [7:0]            slot,
    input  logic                  success,
    input  logic [4:0]            page_shift,
    input  logic [3:0]            sector_shift,
    output logic                  busy,
    output logic                  done,
    output lpcd_pkg::result_t     result
);
    import lpcd_pkg::*;

    localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CW = IW + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SLOT_RD, S_SLOT_WR, S_VICTIM, S_FINISH
    } fsm_t;

    // Memories: tag, stamp (undefined until written); state read as invalid
    // at or above the fill count.
    logic [TagW-1:0]   tag_mem   [CACHE_ENTRIES];
    logic [StampW-1:0] stamp_mem [CACHE_ENTRIES];
    logic [1:0]        st_mem    [CACHE_ENTRIES];
    logic [CW-1:0]     fill_reg;      // entries below this have been written

    fsm_t              state_reg;
    logic [CW-1:0]     cnt_reg;       // issued read address
    logic              rd_v_reg;      // read data in flight is valid
    logic [IW-1:0]     rd_idx_reg;
    logic [TagW-1:0]   tag_q;
    logic [StampW-1:0] stamp_q;
    logic [1:0]        st_q;
    logic [StampW-1:0] clock_reg;
    logic [2:0]        op_reg;
    logic [TagW-1:0]   key_reg;
    logic [LbaW-1:0]   aligned_reg;
    logic [7:0]        slot_reg;
    logic              ok_reg;
    logic [3:0]        ss_reg;
    // Scan findings.
    logic              hit_f_reg, inv_f_reg, cand_f_reg;
    logic [IW-1:0]     hit_i_reg, inv_i_reg, cand_i_reg;
    logic [StampW-1:0] cand_s_reg;
    logic [1:0]        hit_st_reg;
    logic              dirty_f_reg;
    logic [IW-1:0]     dirty_i_reg;
    logic [TagW-1:0]   dirty_t_reg;
    logic [1:0]        cand_st_reg;
    logic [TagW-1:0]   cand_t_reg;
    result_t           res_reg;

    // Memory write port, driven by the FSM.
    logic              we_tag, we_stamp, we_st;
    logic [IW-1:0]     wa;
    logic [TagW-1:0]   wd_tag;
    logic [StampW-1:0] wd_stamp;
    logic [1:0]        wd_st;
    logic [IW-1:0]     ra;

    logic [3:0] ss_c;
    logic [47:0] off_al;
    always_comb begin
        ss_c = (sector_shift < 4'd9) ? 4'd9 : (sector_shift > 4'd12) ? 4'd12 : sector_shift;
    end
    // page_shift 16 does not fit in 4 bits: keep 5-bit page shift register.
    logic [4:0] psw, psw_reg;
    always_comb begin
        psw = (page_shift < 5'd9) ? 5'd9 : (page_shift > 5'd16) ? 5'd16 : page_shift;
        off_al = region_offset & ~((48'd1 << psw) - 48'd1);
    end

    logic [3:0] ss_use;
    assign ss_use = ({1'b0, ss_c} > psw) ? psw[3:0] : ss_c;

    // Synchronous memories with registered read data.
    always_ff @(posedge aclk) begin
        if (we_tag)   tag_mem[wa]   <= wd_tag;
        if (we_stamp) stamp_mem[wa] <= wd_stamp;
        if (we_st)    st_mem[wa]    <= wd_st;
        tag_q   <= tag_mem[ra];
        stamp_q <= stamp_mem[ra];
        st_q    <= st_mem[ra];
    end

    logic [1:0] st_eff;
    assign st_eff = ({1'b0, rd_idx_reg} < fill_reg) ? st_q : ST_INVALID;

    logic slot_ok;
    assign slot_ok = (32'(slot_reg) < 32'(CACHE_ENTRIES));

    logic last_rd;
    assign last_rd = rd_v_reg && ({1'b0, rd_idx_reg} == CW'(CACHE_ENTRIES - 1));

    always_comb begin
        ra = cnt_reg[IW-1:0];
        if (state_reg == S_IDLE) ra = IW'(slot);
        else if (state_reg == S_SLOT_RD) ra = IW'(slot_reg);
    end

    always_comb begin
        we_tag = 1'b0; we_stamp = 1'b0; we_st = 1'b0;
        wa = '0; wd_tag = key_reg; wd_stamp = clock_reg + 64'd1; wd_st = ST_CLEAN;
        if (state_reg == S_VICTIM) begin
            unique case (op_reg)
                OP_FETCH: begin
                    if (hit_f_reg) begin
                        wa = hit_i_reg; we_stamp = 1'b1;
                    end else if (inv_f_reg || cand_f_reg) begin
                        wa = inv_f_reg ? inv_i_reg : cand_i_reg;
                        we_tag = 1'b1; we_stamp = 1'b1; we_st = 1'b1;
                    end
                end
                OP_MARK: begin
                    wa = hit_i_reg; wd_st = ST_DIRTY;
                    we_st = hit_f_reg && (hit_st_reg == ST_CLEAN);
                end
                OP_FLUSH: begin
                    wa = dirty_i_reg; wd_st = ST_WRITING; we_st = dirty_f_reg;
                end
                default: ;
            endcase
        end else if (state_reg == S_SLOT_WR) begin
            wa = IW'(slot_reg);
            if (op_reg == OP_WB_DONE) begin
                wd_st = ok_reg ? ST_CLEAN : ST_DIRTY;
                we_st = slot_ok && st_eff == ST_WRITING;
            end else begin
                wd_st = ST_INVALID;
                we_st = slot_ok && (st_eff == ST_CLEAN || st_eff == ST_DIRTY);
            end
        end
    end

    logic [7:0] cnt_c;
    assign cnt_c = 8'd1 << (psw_reg - {1'b0, ss_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            clock_reg <= '0;
            rd_v_reg  <= 1'b0;
            done      <= 1'b0;
        end else begin
            done <= 1'b0;
            // Advance the fill count when the lowest unwritten entry is installed.
            if (we_st && ({1'b0, wa} == fill_reg)) fill_reg <= fill_reg + CW'(1);
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        op_reg <= opcode; slot_reg <= slot; ok_reg <= success;
                        psw_reg <= psw; ss_reg <= ss_use;
                        aligned_reg <= off_al;
                        key_reg <= off_al[47:9];
                        hit_f_reg <= 1'b0; inv_f_reg <= 1'b0; cand_f_reg <= 1'b0;
                        dirty_f_reg <= 1'b0;
                        rd_idx_reg <= IW'(slot);
                        if (opcode == OP_FETCH || opcode == OP_MARK || opcode == OP_FLUSH) begin
                            cnt_reg <= '0; rd_v_reg <= 1'b0;
                            state_reg <= S_SCAN;
                        end else if (opcode == OP_WB_DONE || opcode == OP_FILL_ERR) begin
                            state_reg <= S_SLOT_RD;
                        end else begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_SCAN: begin
                    // Issue next read, examine the entry read last cycle.
                    if (cnt_reg != CW'(CACHE_ENTRIES)) cnt_reg <= cnt_reg + CW'(1);
                    rd_v_reg <= (cnt_reg != CW'(CACHE_ENTRIES));
                    rd_idx_reg <= cnt_reg[IW-1:0];
                    if (rd_v_reg) begin
                        if (st_eff != ST_INVALID && tag_q == key_reg && !hit_f_reg) begin
                            hit_f_reg <= 1'b1; hit_i_reg <= rd_idx_reg; hit_st_reg <= st_eff;
                        end
                        if (st_eff == ST_INVALID && !inv_f_reg) begin
                            inv_f_reg <= 1'b1; inv_i_reg <= rd_idx_reg;
                        end
                        if (st_eff == ST_DIRTY && !dirty_f_reg) begin
                            dirty_f_reg <= 1'b1; dirty_i_reg <= rd_idx_reg;
                            dirty_t_reg <= tag_q;
                        end
                        if ((st_eff == ST_CLEAN || st_eff == ST_DIRTY)
                            && (!cand_f_reg || stamp_q < cand_s_reg)) begin
                            cand_f_reg <= 1'b1; cand_i_reg <= rd_idx_reg;
                            cand_s_reg <= stamp_q; cand_st_reg <= st_eff;
                            cand_t_reg <= tag_q;
                        end
                    end
                    if (last_rd) begin
                        rd_v_reg <= 1'b0;
                        state_reg <= S_VICTIM;
                    end
                end
                S_VICTIM: begin
                    res_reg <= '0;
                    res_reg.sector_count <= cnt_c;
                    unique case (op_reg)
                        OP_FETCH: begin
                            if (hit_f_reg) begin
                                clock_reg <= clock_reg + 64'd1;
                                res_reg.status <= RS_HIT;
                                res_reg.entry_index <= 8'(hit_i_reg);
                            end else if (inv_f_reg || cand_f_reg) begin
                                clock_reg <= clock_reg + 64'd1;
                                res_reg.status <= RS_FILLED;
                                res_reg.entry_index <= 8'(inv_f_reg ? inv_i_reg : cand_i_reg);
                                res_reg.read_lba <= aligned_reg >> ss_reg;
                                if (!inv_f_reg && cand_st_reg == ST_DIRTY) begin
                                    res_reg.writeback_needed <= 1'b1;
                                    res_reg.writeback_lba <= {cand_t_reg, 9'd0} >> ss_reg;
                                end
                            end else begin
                                res_reg.status <= RS_NO_VICTIM;
                            end
                        end
                        OP_MARK: begin
                            res_reg.status <= hit_f_reg ? RS_DONE : RS_NOT_CACHE;
                            if (hit_f_reg) res_reg.entry_index <= 8'(hit_i_reg);
                        end
                        default: begin
                            res_reg.status <= dirty_f_reg ? RS_DONE : RS_NO_DIRTY;
                            if (dirty_f_reg) begin
                                res_reg.entry_index <= 8'(dirty_i_reg);
                                res_reg.writeback_needed <= 1'b1;
                                res_reg.writeback_lba <= {dirty_t_reg, 9'd0} >> ss_reg;
                            end
                        end
                    endcase
                    done <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_SLOT_RD: state_reg <= S_SLOT_WR;
                S_SLOT_WR: begin
                    res_reg <= '0;
                    res_reg.sector_count <= cnt_c;
                    res_reg.entry_index <= slot_reg;
                    res_reg.status <= we_st ? RS_DONE : RS_IGNORED;
                    done <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_FINISH: begin
                    res_reg <= '0;
                    res_reg.status <= RS_IGNORED;
                    res_reg.sector_count <= cnt_c;
                    done <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign result = res_reg;

    // A finish pulse only leaves a working state.
    a_done_src: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> $past(state_reg) != S_IDLE)
        else $error("done without work");
    // Scan walks in order.
    a_scan_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && $past(state_reg) == S_SCAN && cnt_reg != CW'(0)
         && $past(cnt_reg) != CW'(CACHE_ENTRIES))
        |-> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("scan skipped");
    // Access clock moves only on a fetch result.
    a_clock: assert property (@(posedge aclk) disable iff (!aresetn)
        clock_reg != $past(clock_reg) |-> done && op_reg == OP_FETCH)
        else $error("clock moved");
endmodule

// File: src/lru_page_cache_directory_top.sv
// Top level: stream ports, config registers and result buffer of the directory.
// One item at a time. Fetch, mark dirty and flush scan read every entry of the
// directory memory through its single read port before the result is ready.
// Writeback done and fill failed read and write one entry; unknown opcodes
// go straight to an ignored result. The next item is taken only after the
// result has left the engine. A result waits in the output register while the
// next item is taken. No clearing pass: entries at or above a fill count read
// as invalid.
`timescale 1ns / 1ps
module lru_page_cache_directory_top #(
    parameter int CACHE_ENTRIES = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // opcode[2:0], region_offset[50:3], slot[58:51], success[59]
    input  logic         m_tready,
    output logic         m_tvalid,
    output logic [119:0] m_tdata,   // status, entry_index, read_lba, writeback_needed,
                                    // writeback_lba, sector_count (low to high)
    input  logic         cfg_we,
    input  logic [0:0]   cfg_addr,
    input  logic [4:0]   cfg_wdata
);
    import lpcd_pkg::*;

    logic [4:0] page_shift_reg;
    logic [3:0] sector_shift_reg;
    logic       busy, done;
    result_t    res;
    logic       out_v_reg;
    result_t    out_reg;
    logic       pend_reg;   // engine result waiting for the output register

    // Hold configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_shift_reg <= 5'd12;
            sector_shift_reg <= 4'd9;
        end else if (cfg_we) begin
            if (cfg_addr == CFG_PAGE_SHIFT) page_shift_reg <= cfg_wdata;
            else sector_shift_reg <= cfg_wdata[3:0];
        end
    end

    logic start;
    assign s_tready = !busy && !pend_reg && !done;
    assign start = s_tvalid && s_tready;

    lpcd_engine #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_engine (
        .aclk, .aresetn, .start,
        .opcode(s_tdata[2:0]), .region_offset(s_tdata[50:3]),
        .slot(s_tdata[58:51]), .success(s_tdata[59]),
        .page_shift(page_shift_reg), .sector_shift(sector_shift_reg),
        .busy, .done, .result(res)
    );

    // Move finished result into the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            if (out_v_reg && m_tready) out_v_reg <= 1'b0;
            if ((done || pend_reg) && (!out_v_reg || m_tready)) begin
                out_v_reg <= 1'b1;
                out_reg <= res;
                pend_reg <= 1'b0;
            end else if (done) begin
                pend_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata = {4'd0, out_reg.sector_count, out_reg.writeback_lba,
                      out_reg.writeback_needed, out_reg.read_lba,
                      out_reg.entry_index, out_reg.status};

    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy)
        else $error("accepted item not in work");
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> !pend_reg)
        else $error("result overrun");
    a_pend_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> out_v_reg)
        else $error("pending while output free");
endmodule
